// ===== sv/adhp_pkg.sv =====
// ----------------------------------------------------------------------------
// adhp_pkg
// Shared types and character constants for the ASCII number parser.
// ----------------------------------------------------------------------------
package adhp_pkg;

	localparam int VALUE_BITS = 32;
	localparam int INDEX_BITS = 16;

	localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

	localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE = 8'h39;  // '9'
	localparam logic [7:0] CH_X    = 8'h78;  // 'x'
	localparam logic [7:0] CH_A    = 8'h61;  // 'a'
	localparam logic [7:0] CH_F    = 8'h66;  // 'f'

	// Parser mode, one-hot.
	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_LEAD0 = 4'b0010,
		MODE_DEC   = 4'b0100,
		MODE_HEX   = 4'b1000
	} adhp_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} adhp_req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [INDEX_BITS-1:0] stop_index;
		logic                  was_hex;
	} adhp_rsp_t;

endpackage

// ===== sv/ascii_dec_hex_number_parser_top.sv =====
// ----------------------------------------------------------------------------
// ascii_dec_hex_number_parser_top
// Streams ASCII characters in and returns one unsigned number per string.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one character per request;
//   req.start_req marks the first character of a new string and drops any
//   parse in progress. A leading "0x" selects hexadecimal (0-9, a-f),
//   otherwise digits are decimal 0-9. The value wraps modulo 2^32.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns value, stop_index and
//   was_hex when the first non-digit character (terminator included) ends
//   the string. Characters that continue a string give no response.
// Timing:
//   An accepted request is registered in the input register, then decoded
//   and folded into the accumulator; its response, if any, is captured in
//   the result register as the accumulator updates.
//   One request per cycle is sustained unless a response stalls (see Stall);
//   the limit is the multiply-add feedback on the accumulator.
// Reset:
//   arst_n clears the parse state to idle and empties both registers.
// Stall:
//   While a response waits on rsp_ready, digits keep flowing; a request that
//   would produce a second response holds in the input register and
//   req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module ascii_dec_hex_number_parser_top
	import adhp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  adhp_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output adhp_rsp_t rsp
);

	logic      valid_s1;
	adhp_req_t req_s1;
	logic      emit;
	adhp_rsp_t rsp_next;
	logic      out_free;
	logic      step;
	logic      rsp_valid_q;
	adhp_rsp_t rsp_q;

	// Output register can take a new response this cycle
	assign out_free = !rsp_valid_q || rsp_ready;
	// Advance the held request unless its response would overwrite one waiting
	assign step      = valid_s1 && (!emit || out_free);
	assign req_ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	adhp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req_s1 (req_s1),
		.emit   (emit),
		.rsp    (rsp_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step && emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |-> !(step && emit))
		else $error("waiting response overwritten");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("request taken while result path blocked");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(req_s1))
		else $error("held request lost");
`endif

endmodule

// ===== sv/adhp_digit.sv =====
// ----------------------------------------------------------------------------
// adhp_digit
// Decodes one character into a digit value for base 10 or base 16.
// ----------------------------------------------------------------------------
module adhp_digit
	import adhp_pkg::*;
(
	input  logic [7:0] ch,
	input  logic       hex_en,
	output logic       is_digit,
	output logic [3:0] digit
);

	logic is_dec;
	logic is_hex_letter;

	always_comb begin
		is_dec        = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_hex_letter = hex_en && (ch >= CH_A) && (ch <= CH_F);
		is_digit      = is_dec || is_hex_letter;
		// 'a' has low nibble 1, so add nine for 10..15
		if (is_hex_letter) begin
			digit = ch[3:0] + 4'd9;
		end else begin
			digit = ch[3:0];
		end
	end

endmodule

// ===== sv/adhp_core.sv =====
// ----------------------------------------------------------------------------
// adhp_core
// Parse state (mode, accumulator, position) and its next-state update.
// ----------------------------------------------------------------------------
module adhp_core
	import adhp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  adhp_req_t req_s1,
	output logic      emit,
	output adhp_rsp_t rsp
);

	adhp_mode_t            mode_q, mode_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic [INDEX_BITS-1:0] pos_q, pos_d;

	logic [VALUE_BITS-1:0] acc_base;
	logic [INDEX_BITS-1:0] pos_base;
	logic [INDEX_BITS-1:0] pos_adv;
	logic [VALUE_BITS-1:0] acc_x10;
	logic [VALUE_BITS-1:0] acc_x16;
	logic                  hex_en;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [VALUE_BITS-1:0] digit_ext;

	assign hex_en = !req_s1.start_req && (mode_q == MODE_HEX);

	adhp_digit u_digit (
		.ch       (req_s1.ch),
		.hex_en   (hex_en),
		.is_digit (is_digit),
		.digit    (digit)
	);

	always_comb begin
		acc_base  = req_s1.start_req ? '0 : acc_q;
		pos_base  = req_s1.start_req ? '0 : pos_q;
		pos_adv   = (pos_base == INDEX_MAX) ? pos_base : pos_base + 1'b1;
		digit_ext = {{(VALUE_BITS-4){1'b0}}, digit};
		acc_x10   = (acc_base << 3) + (acc_base << 1);
		acc_x16   = acc_base << 4;

		mode_d = mode_q;
		acc_d  = acc_q;
		pos_d  = pos_q;
		emit   = 1'b0;
		rsp.value      = acc_base;
		rsp.stop_index = pos_base;
		rsp.was_hex    = 1'b0;

		if (req_s1.start_req) begin
			if (req_s1.ch == CH_ZERO) begin
				mode_d = MODE_LEAD0;
				acc_d  = '0;
				pos_d  = pos_adv;
			end else if (is_digit) begin
				mode_d = MODE_DEC;
				acc_d  = digit_ext;
				pos_d  = pos_adv;
			end else begin
				emit = 1'b1;
			end
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					// hold: stray character outside a string
				end
				MODE_LEAD0: begin
					if (req_s1.ch == CH_X) begin
						mode_d = MODE_HEX;
						acc_d  = '0;
						pos_d  = pos_adv;
					end else if (is_digit) begin
						mode_d = MODE_DEC;
						acc_d  = digit_ext;
						pos_d  = pos_adv;
					end else begin
						emit = 1'b1;
					end
				end
				MODE_DEC: begin
					if (is_digit) begin
						acc_d = acc_x10 + digit_ext;
						pos_d = pos_adv;
					end else begin
						emit = 1'b1;
					end
				end
				MODE_HEX: begin
					if (is_digit) begin
						acc_d = acc_x16 + digit_ext;
						pos_d = pos_adv;
					end else begin
						emit        = 1'b1;
						rsp.was_hex = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase
		end

		// drop state once a result leaves
		if (emit) begin
			mode_d = MODE_IDLE;
			acc_d  = '0;
			pos_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			pos_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			pos_q  <= pos_d;
		end
	end

`ifndef SYNTHESIS
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> (mode_q == MODE_IDLE) && (acc_q == '0) && (pos_q == '0))
		else $error("parse state not cleared after result");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && !req_s1.start_req && (mode_q == MODE_IDLE) |-> !emit)
		else $error("result produced while idle");

	a_hex_origin: assert property (@(posedge clk) disable iff (!arst_n)
		emit && rsp.was_hex |-> !req_s1.start_req && (mode_q == MODE_HEX))
		else $error("hex flag outside hex mode");

	a_pos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		step && !emit && (mode_d != mode_q || acc_d != acc_q) |-> pos_d != '0)
		else $error("position not advanced on consumed digit");
`endif

endmodule
